[rtl/bpp_pkg.sv]
// Shared types and constants of the beat peak picker with cluster merge.
// Used by the sequencer, the serial divider, the top level and the checker.
package bpp_pkg;

  // Fixed field widths
  localparam int unsigned LOGIT_BITS  = 16;
  localparam int unsigned POS_BITS    = 32;
  localparam int unsigned COUNT_BITS  = 6;
  localparam int unsigned WIDTH_BITS  = 4;
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned APB_ADDR_BITS = 3;

  // Cluster limit and register reset
  localparam logic [COUNT_BITS-1:0] COUNT_MAX     = 6'd63;
  localparam logic [WIDTH_BITS-1:0] DEDUP_RESET   = 4'd1;

  // Register index of dedup_width (byte address 4*index)
  localparam logic REG_DEDUP_WIDTH = 1'b0;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_MUL,
    ST_TEST,
    ST_DIV,
    ST_PUSH,
    ST_NEXT,
    ST_DONE
  } seq_state_e;

  // Control bits of one result word handed to the output register
  typedef struct packed {
    logic valid;
    logic last;
    logic eos;
  } res_ctrl_t;

endpackage

[rtl/bpp_div.sv]
// Restoring serial divider, one quotient bit per cycle, for the cluster mean.
// Depends on bpp_pkg for the count and position widths.
module bpp_div #(
  parameter int unsigned DVD_BITS = 38
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [DVD_BITS-1:0]               dividend_i,
  input  logic [bpp_pkg::COUNT_BITS-1:0]    divisor_i,
  output logic                              busy_o,
  output logic [bpp_pkg::POS_BITS-1:0]      quotient_o
);

  localparam int unsigned CNT_BITS = $clog2(DVD_BITS + 1);

  logic [DVD_BITS-1:0]               dvd_q;
  logic [bpp_pkg::COUNT_BITS-1:0]    dvs_q;
  logic [bpp_pkg::COUNT_BITS-1:0]    rem_q;
  logic [bpp_pkg::POS_BITS-1:0]      quo_q;
  logic [CNT_BITS-1:0]               cnt_q;
  logic                              busy_q;

  logic [bpp_pkg::COUNT_BITS:0]      trial_w;
  logic                              fits_w;
  logic [bpp_pkg::COUNT_BITS:0]      diff_w;

  // Trial subtract of the divisor from the shifted partial remainder
  assign trial_w = {rem_q, dvd_q[DVD_BITS-1]};
  assign fits_w  = trial_w >= {1'b0, dvs_q};
  assign diff_w  = trial_w - {1'b0, dvs_q};

  // Control: count the quotient bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_BITS'(DVD_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: shift dividend out, quotient bits in; only the low bits are kept
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_BITS-2:0], 1'b0};
      rem_q <= fits_w ? diff_w[bpp_pkg::COUNT_BITS-1:0] : trial_w[bpp_pkg::COUNT_BITS-1:0];
      quo_q <= {quo_q[bpp_pkg::POS_BITS-2:0], fits_w};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

[rtl/bpp_seq.sv]
// Sequencer of the peak picker: logit window, serial peak scan, cluster
// merge test and result staging. Depends on bpp_pkg and drives bpp_div.
module bpp_seq #(
  parameter int unsigned PEAK_RADIUS      = 3,
  parameter int unsigned FRAME_INDEX_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [bpp_pkg::LOGIT_BITS-1:0] logit_i,
  input  logic                                  last_frame_i,
  input  logic [bpp_pkg::WIDTH_BITS-1:0]        dedup_width_i,
  output logic                                  div_start_o,
  output logic [FRAME_INDEX_BITS+bpp_pkg::COUNT_BITS+bpp_pkg::FRAC_BITS-1:0] div_dividend_o,
  output logic [bpp_pkg::COUNT_BITS-1:0]        div_divisor_o,
  input  logic                                  div_busy_i,
  input  logic [bpp_pkg::POS_BITS-1:0]          div_quotient_i,
  output bpp_pkg::res_ctrl_t                    res_o,
  output logic [bpp_pkg::POS_BITS-1:0]          res_pos_o,
  input  logic                                  res_ready_i
);

  localparam int unsigned WIN_DEPTH    = 2 * PEAK_RADIUS + 1;
  localparam int unsigned WIN_IDX_BITS = $clog2(WIN_DEPTH);
  localparam int unsigned FILL_BITS    = $clog2(WIN_DEPTH + 1);
  localparam int unsigned DIST_BITS    = $clog2(PEAK_RADIUS + 1);
  localparam int unsigned SUM_BITS     = FRAME_INDEX_BITS + bpp_pkg::COUNT_BITS;
  localparam int unsigned CMP_BITS     = SUM_BITS + 1;

  bpp_pkg::seq_state_e state_q, state_d;

  logic signed [bpp_pkg::LOGIT_BITS-1:0] win_q [WIN_DEPTH];
  logic [FILL_BITS-1:0]                  fill_q;
  logic [FRAME_INDEX_BITS-1:0]           frame_q;
  logic [FRAME_INDEX_BITS-1:0]           newest_q;
  logic                                  last_q;
  logic [DIST_BITS-1:0]                  dist_q;
  logic [WIN_IDX_BITS-1:0]               k_q;
  logic [WIN_IDX_BITS-1:0]               hi_q;
  logic signed [bpp_pkg::LOGIT_BITS-1:0] cand_q;
  logic [FRAME_INDEX_BITS-1:0]           idx_q;
  logic [SUM_BITS-1:0]                   prod_q;
  logic [SUM_BITS-1:0]                   sum_q;
  logic [bpp_pkg::COUNT_BITS-1:0]        count_q;
  logic                                  open_q;
  logic                                  flush_q;
  logic [bpp_pkg::POS_BITS-1:0]          pend_pos_q;
  logic                                  pend_valid_q;
  logic                                  pend_eos_q;

  logic                                  accept_w;
  logic [WIN_IDX_BITS-1:0]               rd_idx_w;
  logic signed [bpp_pkg::LOGIT_BITS-1:0] win_rd_w;
  logic                                  cand_ok_w;
  logic [FILL_BITS-1:0]                  reach_w;
  logic [FILL_BITS-1:0]                  fill_m1_w;
  logic [FILL_BITS-1:0]                  hi_w;
  logic [FRAME_INDEX_BITS-1:0]           idx_w;
  logic signed [CMP_BITS-1:0]            lhs_w;
  logic signed [CMP_BITS-1:0]            rhs_w;
  logic                                  merge_w;
  logic                                  stream_end_w;
  logic                                  close_w;
  logic                                  stage_free_w;

  assign accept_w = in_valid_i && in_ready_o;

  // One window read port: candidate in LOAD, scanned neighbour in SCAN
  assign rd_idx_w = (state_q == bpp_pkg::ST_LOAD) ? WIN_IDX_BITS'(dist_q) : k_q;
  assign win_rd_w = win_q[rd_idx_w];

  // Candidate exists and is positive
  assign cand_ok_w = (FILL_BITS'(dist_q) < fill_q) && (win_rd_w > 0);

  // Last scanned entry: older side cut short by the frames present
  assign reach_w   = FILL_BITS'(dist_q) + FILL_BITS'(PEAK_RADIUS);
  assign fill_m1_w = fill_q - FILL_BITS'(1);
  assign hi_w      = (reach_w < fill_m1_w) ? reach_w : fill_m1_w;

  // Frame index of the candidate, wrapping with the counter
  assign idx_w = newest_q - FRAME_INDEX_BITS'(dist_q);

  // Merge test: idx*count - sum <= width*count
  assign lhs_w = $signed({1'b0, prod_q}) - $signed({1'b0, sum_q});
  assign rhs_w = $signed({1'b0, SUM_BITS'(dedup_width_i) * SUM_BITS'(count_q)});
  assign merge_w = open_q && (count_q != bpp_pkg::COUNT_MAX) && (lhs_w <= rhs_w);

  assign stream_end_w = last_q && (dist_q == '0);
  assign stage_free_w = !pend_valid_q || res_ready_i;

  // Start of a cluster mean division
  assign close_w = ((state_q == bpp_pkg::ST_TEST) && !merge_w && open_q) ||
                   ((state_q == bpp_pkg::ST_NEXT) && stream_end_w && open_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bpp_pkg::ST_IDLE: begin
        if (accept_w) begin
          state_d = bpp_pkg::ST_LOAD;
        end
      end
      bpp_pkg::ST_LOAD: begin
        state_d = cand_ok_w ? bpp_pkg::ST_SCAN : bpp_pkg::ST_NEXT;
      end
      bpp_pkg::ST_SCAN: begin
        if (win_rd_w > cand_q) begin
          state_d = bpp_pkg::ST_NEXT;
        end else if (k_q == hi_q) begin
          state_d = bpp_pkg::ST_MUL;
        end
      end
      bpp_pkg::ST_MUL: begin
        state_d = bpp_pkg::ST_TEST;
      end
      bpp_pkg::ST_TEST: begin
        state_d = close_w ? bpp_pkg::ST_DIV : bpp_pkg::ST_NEXT;
      end
      bpp_pkg::ST_DIV: begin
        if (!div_busy_i) begin
          state_d = bpp_pkg::ST_PUSH;
        end
      end
      bpp_pkg::ST_PUSH: begin
        if (stage_free_w) begin
          state_d = flush_q ? bpp_pkg::ST_DONE : bpp_pkg::ST_NEXT;
        end
      end
      bpp_pkg::ST_NEXT: begin
        if (last_q && (dist_q != '0)) begin
          state_d = bpp_pkg::ST_LOAD;
        end else if (close_w) begin
          state_d = bpp_pkg::ST_DIV;
        end else begin
          state_d = bpp_pkg::ST_DONE;
        end
      end
      bpp_pkg::ST_DONE: begin
        if (stage_free_w) begin
          state_d = bpp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bpp_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o  = 1'b0;
    res_o       = '0;
    div_start_o = close_w;
    case (state_q)
      bpp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      bpp_pkg::ST_PUSH: begin
        res_o.valid = pend_valid_q;
        res_o.last  = 1'b0;
        res_o.eos   = pend_eos_q;
      end
      bpp_pkg::ST_DONE: begin
        res_o.valid = pend_valid_q;
        res_o.last  = 1'b1;
        res_o.eos   = pend_eos_q;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign div_dividend_o = {sum_q, {bpp_pkg::FRAC_BITS{1'b0}}};
  assign div_divisor_o  = count_q;
  assign res_pos_o      = pend_pos_q;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Stream and cluster control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      frame_q      <= '0;
      sum_q        <= '0;
      count_q      <= '0;
      open_q       <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (accept_w) begin
        if (fill_q != FILL_BITS'(WIN_DEPTH)) begin
          fill_q <= fill_q + FILL_BITS'(1);
        end
        frame_q <= frame_q + FRAME_INDEX_BITS'(1);
      end
      // Merge the peak, or open a new cluster with it
      if (state_q == bpp_pkg::ST_TEST) begin
        if (merge_w) begin
          sum_q   <= sum_q + SUM_BITS'(idx_q);
          count_q <= count_q + bpp_pkg::COUNT_BITS'(1);
        end else begin
          sum_q   <= SUM_BITS'(idx_q);
          count_q <= bpp_pkg::COUNT_BITS'(1);
          open_q  <= 1'b1;
        end
      end
      // Drop all stream state after the final frame
      if ((state_q == bpp_pkg::ST_NEXT) && stream_end_w) begin
        fill_q  <= '0;
        frame_q <= '0;
        sum_q   <= '0;
        count_q <= '0;
        open_q  <= 1'b0;
      end
      // Stage a finished mean; hand the staged one on first
      if ((state_q == bpp_pkg::ST_PUSH) && stage_free_w) begin
        pend_valid_q <= 1'b1;
      end
      if ((state_q == bpp_pkg::ST_DONE) && stage_free_w) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  // Window, scan and staging payload
  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      for (int unsigned i = WIN_DEPTH - 1; i > 0; i--) begin
        win_q[i] <= win_q[i-1];
      end
      win_q[0] <= logit_i;
      newest_q <= frame_q;
      last_q   <= last_frame_i;
      dist_q   <= DIST_BITS'(PEAK_RADIUS);
    end
    if (state_q == bpp_pkg::ST_LOAD) begin
      cand_q <= win_rd_w;
      k_q    <= '0;
      hi_q   <= WIN_IDX_BITS'(hi_w);
    end
    if (state_q == bpp_pkg::ST_SCAN) begin
      k_q <= k_q + WIN_IDX_BITS'(1);
    end
    if (state_q == bpp_pkg::ST_MUL) begin
      idx_q  <= idx_w;
      prod_q <= SUM_BITS'(idx_w) * SUM_BITS'(count_q);
    end
    if (close_w) begin
      flush_q <= (state_q == bpp_pkg::ST_NEXT);
    end
    if ((state_q == bpp_pkg::ST_NEXT) && last_q && (dist_q != '0)) begin
      dist_q <= dist_q - DIST_BITS'(1);
    end
    if ((state_q == bpp_pkg::ST_PUSH) && stage_free_w) begin
      pend_pos_q <= div_quotient_i;
      pend_eos_q <= flush_q;
    end
  end

endmodule

[rtl/beat_peak_picker_dedup.sv]
// Top level of the beat peak picker with cluster merge: configuration port,
// output register and the sequencer with its serial divider.
// Depends on bpp_pkg, bpp_seq and bpp_div.

// One frame word is taken at a time and s_axis_tready stays low until the frame
// is finished. For each frame, its candidate is compared against each neighbour in
// turn by one comparator, then the merge test uses one multiply and one compare.
// Each closed cluster adds a run of the serial divider, one quotient bit a cycle.
// The final frame (tlast) checks PEAK_RADIUS+1 pending frames and may close up to
// PEAK_RADIUS+2 clusters, each with its own division. Results leave through an
// output register, so a waiting result holds back the block only when the next
// one is ready.
module beat_peak_picker_dedup #(
  parameter int unsigned PEAK_RADIUS      = 3,
  parameter int unsigned FRAME_INDEX_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Frame stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [bpp_pkg::LOGIT_BITS-1:0]       s_axis_tdata,   // [15:0] logit
  input  logic                                 s_axis_tlast,   // last_frame
  // Cluster stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [bpp_pkg::POS_BITS-1:0]         m_axis_tdata,   // [31:0] peak_position
  output logic                                 m_axis_tlast,   // last_in_run
  output logic                                 m_axis_tuser,   // [0] end_of_stream
  // Configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bpp_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [bpp_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [bpp_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                 pready
);

  localparam int unsigned DVD_BITS =
    FRAME_INDEX_BITS + bpp_pkg::COUNT_BITS + bpp_pkg::FRAC_BITS;

  logic [bpp_pkg::WIDTH_BITS-1:0]  dedup_q;
  logic                            reg_sel_w;

  logic                            div_start_w;
  logic [DVD_BITS-1:0]             div_dividend_w;
  logic [bpp_pkg::COUNT_BITS-1:0]  div_divisor_w;
  logic                            div_busy_w;
  logic [bpp_pkg::POS_BITS-1:0]    div_quotient_w;

  bpp_pkg::res_ctrl_t              res_w;
  logic [bpp_pkg::POS_BITS-1:0]    res_pos_w;
  logic                            res_ready_w;

  logic                            out_valid_q;
  logic [bpp_pkg::POS_BITS-1:0]    out_pos_q;
  logic                            out_last_q;
  logic                            out_eos_q;

  // Register file: dedup_width only
  assign pready    = 1'b1;
  assign reg_sel_w = (paddr[2] == bpp_pkg::REG_DEDUP_WIDTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dedup_q <= bpp_pkg::DEDUP_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel_w) begin
      dedup_q <= pwdata[bpp_pkg::WIDTH_BITS-1:0];
    end
  end

  assign prdata = reg_sel_w ? bpp_pkg::APB_DATA_BITS'(dedup_q) : '0;

  bpp_seq #(
    .PEAK_RADIUS      (PEAK_RADIUS),
    .FRAME_INDEX_BITS (FRAME_INDEX_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .logit_i        ($signed(s_axis_tdata)),
    .last_frame_i   (s_axis_tlast),
    .dedup_width_i  (dedup_q),
    .div_start_o    (div_start_w),
    .div_dividend_o (div_dividend_w),
    .div_divisor_o  (div_divisor_w),
    .div_busy_i     (div_busy_w),
    .div_quotient_i (div_quotient_w),
    .res_o          (res_w),
    .res_pos_o      (res_pos_w),
    .res_ready_i    (res_ready_w)
  );

  bpp_div #(
    .DVD_BITS (DVD_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_w),
    .dividend_i (div_dividend_w),
    .divisor_i  (div_divisor_w),
    .busy_o     (div_busy_w),
    .quotient_o (div_quotient_w)
  );

  // Output register: take a word whenever the slot is empty or being drained
  assign res_ready_w = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready_w) begin
      out_valid_q <= res_w.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_w && res_w.valid) begin
      out_pos_q  <= res_pos_w;
      out_last_q <= res_w.last;
      out_eos_q  <= res_w.eos;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pos_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_eos_q;

endmodule

[rtl/bpp_checker.sv]
// Port-level checks of the beat peak picker, attached to the top level by bind.
// Depends on bpp_pkg for port widths.
module bpp_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  input  logic                                 s_axis_tready,
  input  logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic [bpp_pkg::POS_BITS-1:0]         m_axis_tdata,
  input  logic                                 m_axis_tlast,
  input  logic                                 m_axis_tuser,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bpp_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [bpp_pkg::APB_DATA_BITS-1:0]    pwdata,
  input  logic [bpp_pkg::APB_DATA_BITS-1:0]    prdata
);

  // A frame keeps the block busy for at least the following cycle
  a_busy_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("frame taken in back-to-back cycles");

  // The end-of-stream cluster closes its run
  a_eos_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("end-of-stream word not marked last");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // dedup_width reads back what was written
  a_reg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[2] == bpp_pkg::REG_DEDUP_WIDTH) |=>
      (paddr[2] != bpp_pkg::REG_DEDUP_WIDTH) ||
      (prdata == bpp_pkg::APB_DATA_BITS'($past(pwdata[bpp_pkg::WIDTH_BITS-1:0]))))
    else $error("dedup_width read-back mismatch");

endmodule

bind beat_peak_picker_dedup bpp_checker u_bpp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);
